FILE: sv/assert_macros.svh
// assertion macros shared by the framer rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

FILE: sv/ffe_pkg.sv
// shared types and constants of the fix frame extractor
// no dependencies
package ffe_pkg;

	localparam int BYTE_W     = 8;
	localparam int CFG_W      = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	localparam logic [BYTE_W-1:0] CHAR_SOH = 8'h01;
	localparam logic [BYTE_W-1:0] CHAR_0   = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_1   = 8'h31;
	localparam logic [BYTE_W-1:0] CHAR_8   = 8'h38;
	localparam logic [BYTE_W-1:0] CHAR_9   = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_EQ  = 8'h3D;

	typedef enum logic [3:0] {
		PH_HUNT,
		PH_GOT8,
		PH_HDR,
		PH_HDR_FS,
		PH_HDR_9,
		PH_LEN,
		PH_BODY,
		PH_T1,
		PH_T0,
		PH_TEQ,
		PH_TVAL
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_TRAILER,
		ST_BADLEN,
		ST_TOOBIG
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              byte_valid;
		logic              first_of_frame;
		logic              last_of_frame;
		status_t           frame_status;
		logic              last_of_step;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

FILE: sv/ffe_out_fifo.sv
// four-word result queue, takes up to two words per cycle
// depends on ffe_pkg and assert_macros.svh
`include "assert_macros.svh"

module ffe_out_fifo import ffe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	res_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 pop;

	assign out_valid = (count_q != '0);
	assign out_res   = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign room      = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + FIFO_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + FIFO_CW'(push.n) - FIFO_CW'(pop);
		end
	end

	`ASSERT_NEVER(a_fifo_overflow, count_q > FIFO_CW'(FIFO_DEPTH), "result queue overflow")
	`ASSERT_CLK(a_push_needs_room, (push.n != 2'd0) |-> room, "push without room")
	`ASSERT_CLK(a_empty_ptrs, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q), "pointers apart when empty")

endmodule

FILE: sv/ffe_parser.sv
// input register and frame parse state machine
// depends on ffe_pkg and assert_macros.svh
`include "assert_macros.svh"

module ffe_parser import ffe_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic [CFG_W-1:0]  max_len,
	input  logic              room,
	output push_t             push
);

	localparam int MW = LENGTH_BITS + 4;
	localparam int CW = LENGTH_BITS + CFG_W;

	logic                   valid_s1;
	logic [BYTE_W-1:0]      byte_s1;
	logic                   advance;

	phase_t                 phase_q, phase_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;
	logic [LENGTH_BITS-1:0] acc_q, acc_d;
	logic                   big_q, big_d;
	logic                   seen_q, seen_d;

	res_t                   res0, res1;
	logic [1:0]             n;
	logic [MW-1:0]          acc_next;
	logic                   is_digit;
	logic [BYTE_W-1:0]      want;

	function automatic res_t mk_res(logic [BYTE_W-1:0] b, logic v, logic f, logic l,
			status_t s);
		res_t r;
		r.data           = b;
		r.byte_valid     = v;
		r.first_of_frame = f;
		r.last_of_frame  = l;
		r.frame_status   = s;
		r.last_of_step   = 1'b0;
		return r;
	endfunction

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			rem_q   <= '0;
			acc_q   <= '0;
			big_q   <= 1'b0;
			seen_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			acc_q   <= acc_d;
			big_q   <= big_d;
			seen_q  <= seen_d;
		end
	end

	assign is_digit = (byte_s1 >= CHAR_0) && (byte_s1 <= CHAR_9);
	assign acc_next = MW'({acc_q, 3'b000}) + MW'({acc_q, 1'b0})
		+ MW'(4'(byte_s1 - CHAR_0));

	always_comb begin
		phase_d = phase_q;
		rem_d   = rem_q;
		acc_d   = acc_q;
		big_d   = big_q;
		seen_d  = seen_q;
		res0    = '0;
		res1    = '0;
		n       = 2'd0;
		want    = CHAR_EQ;
		unique case (phase_q)
			PH_GOT8: begin
				if (byte_s1 == CHAR_EQ) begin
					res0    = mk_res(CHAR_8, 1'b1, 1'b1, 1'b0, ST_OK);
					res1    = mk_res(byte_s1, 1'b1, 1'b0, 1'b0, ST_OK);
					n       = 2'd2;
					phase_d = PH_HDR;
				end else if (byte_s1 != CHAR_8) begin
					phase_d = PH_HUNT;
				end
			end
			PH_HDR, PH_HDR_FS, PH_HDR_9: begin
				res0 = mk_res(byte_s1, 1'b1, 1'b0, 1'b0, ST_OK);
				n    = 2'd1;
				if (byte_s1 == CHAR_SOH) begin
					phase_d = PH_HDR_FS;
				end else if (phase_q == PH_HDR_FS && byte_s1 == CHAR_9) begin
					phase_d = PH_HDR_9;
				end else if (phase_q == PH_HDR_9 && byte_s1 == CHAR_EQ) begin
					phase_d = PH_LEN;
					acc_d   = '0;
					big_d   = 1'b0;
					seen_d  = 1'b0;
				end else begin
					phase_d = PH_HDR;
				end
			end
			PH_LEN: begin
				n = 2'd1;
				if (is_digit) begin
					if (acc_next[MW-1:LENGTH_BITS] != '0) begin
						acc_d = '1;
						big_d = 1'b1;
					end else begin
						acc_d = acc_next[LENGTH_BITS-1:0];
					end
					seen_d = 1'b1;
					res0   = mk_res(byte_s1, 1'b1, 1'b0, 1'b0, ST_OK);
				end else if (byte_s1 == CHAR_SOH) begin
					if (!seen_q) begin
						res0    = mk_res(byte_s1, 1'b1, 1'b0, 1'b1, ST_BADLEN);
						phase_d = PH_HUNT;
					end else if (big_q || (CW'(acc_q) > CW'(max_len))) begin
						res0    = mk_res(byte_s1, 1'b1, 1'b0, 1'b1, ST_TOOBIG);
						phase_d = PH_HUNT;
					end else begin
						res0    = mk_res(byte_s1, 1'b1, 1'b0, 1'b0, ST_OK);
						rem_d   = acc_q;
						phase_d = (acc_q != '0) ? PH_BODY : PH_T1;
					end
				end else begin
					res0    = mk_res(byte_s1, 1'b1, 1'b0, 1'b1, ST_BADLEN);
					phase_d = PH_HUNT;
				end
			end
			PH_BODY: begin
				res0  = mk_res(byte_s1, 1'b1, 1'b0, 1'b0, ST_OK);
				n     = 2'd1;
				rem_d = rem_q - LENGTH_BITS'(1);
				if (rem_d == '0) begin
					phase_d = PH_T1;
				end
			end
			PH_T1, PH_T0, PH_TEQ: begin
				n = 2'd1;
				if (phase_q == PH_T1) begin
					want = CHAR_1;
				end else if (phase_q == PH_T0) begin
					want = CHAR_0;
				end
				if (byte_s1 == want) begin
					res0 = mk_res(byte_s1, 1'b1, 1'b0, 1'b0, ST_OK);
					if (phase_q == PH_T1) begin
						phase_d = PH_T0;
					end else if (phase_q == PH_T0) begin
						phase_d = PH_TEQ;
					end else begin
						phase_d = PH_TVAL;
					end
				end else begin
					res0    = mk_res('0, 1'b0, 1'b0, 1'b1, ST_TRAILER);
					phase_d = (byte_s1 == CHAR_8) ? PH_GOT8 : PH_HUNT;
				end
			end
			PH_TVAL: begin
				n = 2'd1;
				if (byte_s1 == CHAR_SOH) begin
					res0    = mk_res(byte_s1, 1'b1, 1'b0, 1'b1, ST_OK);
					phase_d = PH_HUNT;
				end else begin
					res0 = mk_res(byte_s1, 1'b1, 1'b0, 1'b0, ST_OK);
				end
			end
			default: begin
				phase_d = (byte_s1 == CHAR_8) ? PH_GOT8 : PH_HUNT;
			end
		endcase
		if (n == 2'd1) begin
			res0.last_of_step = 1'b1;
		end else if (n == 2'd2) begin
			res1.last_of_step = 1'b1;
		end
	end

	assign push.n  = advance ? n : 2'd0;
	assign push.r0 = res0;
	assign push.r1 = res1;

	`ASSERT_CLK(a_pair_opens_frame, (push.n == 2'd2) |-> push.r0.first_of_frame,
		"two words without frame start")
	`ASSERT_CLK(a_step_mark, (push.n == 2'd2) |-> (push.r1.last_of_step && !push.r0.last_of_step),
		"step mark misplaced")
	`ASSERT_NEVER(a_body_nonzero, phase_q == PH_BODY && rem_q == '0, "body count zero in body")
	`ASSERT_CLK(a_term_closes, (push.n != 2'd0 && !push.r0.byte_valid) |->
		(push.r0.last_of_frame && push.r0.frame_status == ST_TRAILER), "bad terminator word")

endmodule

FILE: sv/fix_frame_extractor.sv
// Byte-serial FIX message framer.
//
// s_axis: one received stream byte per word in s_axis_tdata[7:0].
// m_axis: frame bytes and terminator words. tdata[7:0] is the byte,
//   tlast marks the word that closes a frame and tuser carries the flags
//   (byte_valid, first_of_frame, frame_status, last_of_step).
// cfg_we / cfg_wdata: write of max_body_length, only while the block is idle.
//
// An accepted byte is held in the input register; its result words are
// queued once the queue has room. One byte is taken every cycle while
// the queue has room; the opening "8=" gives two words from one byte,
// which the four-word result queue absorbs while the next bytes come.
// Reset puts the parser in hunt, empties the queue and sets max_body_length
// to 65535. When m_axis stalls the queue fills, the input register holds its
// byte and s_axis_tready drops until at least two queue slots are free.
// Bytes outside a frame give no words.
module fix_frame_extractor import ffe_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [BYTE_W-1:0] s_axis_tdata,  // in_byte
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [BYTE_W-1:0] m_axis_tdata,  // out_byte
	output logic              m_axis_tlast,  // last_of_frame
	output logic [4:0]        m_axis_tuser,  // byte_valid, first_of_frame, frame_status[1:0], last_of_step
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	logic [CFG_W-1:0] max_len_q;
	logic             room;
	push_t            push;
	res_t             out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= '1;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	ffe_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_byte (s_axis_tdata),
		.max_len (max_len_q),
		.room    (room),
		.push    (push)
	);

	ffe_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (out_res)
	);

	assign m_axis_tdata = out_res.data;
	assign m_axis_tlast = out_res.last_of_frame;
	assign m_axis_tuser = {out_res.last_of_step, out_res.frame_status,
		out_res.first_of_frame, out_res.byte_valid};

endmodule
